### hw/rtl/irpd_pkg.sv
// Package: shared types, register codes and reset constants of the IR pulse-distance encoder.
package irpd_pkg;

   // Default number of bits sent per input byte
   localparam int BITS_PER_BYTE_DEF = 8;

   // Field widths
   localparam int DATA_W  = 8;
   localparam int DUR_W   = 16;
   localparam int CSR_IDX_W = 3;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Register reset values in microseconds
   localparam logic [DUR_W-1:0] HEADER_MARK_RST  = 16'd4400;
   localparam logic [DUR_W-1:0] HEADER_SPACE_RST = 16'd4400;
   localparam logic [DUR_W-1:0] BIT_MARK_RST     = 16'd560;
   localparam logic [DUR_W-1:0] ZERO_SPACE_RST   = 16'd560;
   localparam logic [DUR_W-1:0] ONE_SPACE_RST    = 16'd1690;

   // Shortest segment sent when a register holds zero
   localparam logic [DUR_W-1:0] MIN_DUR = 16'd1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEADER_MARK  = 3'd0,
      REG_HEADER_SPACE = 3'd1,
      REG_BIT_MARK     = 3'd2,
      REG_ZERO_SPACE   = 3'd3,
      REG_ONE_SPACE    = 3'd4
   } reg_idx_type;

   // Segment sequencer phases
   typedef enum logic [1:0] {
      PH_HDR_MARK,
      PH_HDR_SPACE,
      PH_BIT_MARK,
      PH_BIT_SPACE
   } phase_type;

   // Timing configuration
   typedef struct packed {
      logic [DUR_W-1:0] header_mark_us;
      logic [DUR_W-1:0] header_space_us;
      logic [DUR_W-1:0] bit_mark_us;
      logic [DUR_W-1:0] zero_space_us;
      logic [DUR_W-1:0] one_space_us;
   } cfg_type;

   // One queued input byte
   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              frame_start;
      logic              frame_end;
   } item_type;

   // Queue to sequencer handshake
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

### hw/rtl/irpd_if.sv
// Interfaces: request, response and register write channels.
interface irpd_req_if;
   logic                         valid;
   logic                         ready;
   logic [irpd_pkg::DATA_W-1:0]  data_byte;
   logic                         frame_start;
   logic                         frame_end;

   modport source (output valid, output data_byte, output frame_start, output frame_end,
                   input ready);
   modport sink   (input valid, input data_byte, input frame_start, input frame_end,
                   output ready);
endinterface

interface irpd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         carrier_on;
   logic [irpd_pkg::DUR_W-1:0]   duration_us;
   logic                         item_last;
   logic                         frame_done;

   modport source (output valid, output carrier_on, output duration_us, output item_last,
                   output frame_done, input ready);
   modport sink   (input valid, input carrier_on, input duration_us, input item_last,
                   input frame_done, output ready);
endinterface

interface irpd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [irpd_pkg::CSR_IDX_W-1:0]  index;
   logic [irpd_pkg::DUR_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/irpd_csr.sv
// Timing register file written through the register write channel.
module irpd_csr (
   input  logic              clock,
   input  logic              reset,
   irpd_csr_if.sink          csr_bus,
   output irpd_pkg::cfg_type cfg
);

   irpd_pkg::cfg_type cfg_ff;
   irpd_pkg::cfg_type cfg_in;

   // Always take a transfer
   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   // Decode the written index, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (irpd_pkg::reg_idx_type'(csr_bus.index))
            irpd_pkg::REG_HEADER_MARK:  cfg_in.header_mark_us  = csr_bus.data;
            irpd_pkg::REG_HEADER_SPACE: cfg_in.header_space_us = csr_bus.data;
            irpd_pkg::REG_BIT_MARK:     cfg_in.bit_mark_us     = csr_bus.data;
            irpd_pkg::REG_ZERO_SPACE:   cfg_in.zero_space_us   = csr_bus.data;
            irpd_pkg::REG_ONE_SPACE:    cfg_in.one_space_us    = csr_bus.data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark_us  <= irpd_pkg::HEADER_MARK_RST;
         cfg_ff.header_space_us <= irpd_pkg::HEADER_SPACE_RST;
         cfg_ff.bit_mark_us     <= irpd_pkg::BIT_MARK_RST;
         cfg_ff.zero_space_us   <= irpd_pkg::ZERO_SPACE_RST;
         cfg_ff.one_space_us    <= irpd_pkg::ONE_SPACE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/irpd_queue.sv
// Front end: accepts request transfers into a short register queue.
module irpd_queue (
   input  logic                    clock,
   input  logic                    reset,
   irpd_req_if.sink                req_bus,
   output irpd_pkg::queue_out_type q_out,
   input  logic                    q_pop
);

   localparam int PTR_W = (irpd_pkg::QUEUE_DEPTH > 1) ? $clog2(irpd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(irpd_pkg::QUEUE_DEPTH + 1);

   irpd_pkg::item_type slot_ff [irpd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   // Accept while there is room
   assign req_bus.ready = (count_ff != CNT_W'(irpd_pkg::QUEUE_DEPTH));
   assign push = req_bus.valid && req_bus.ready;
   assign pop  = q_pop && (count_ff != '0);

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(irpd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(irpd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the payload of each transfer
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].data_byte   <= req_bus.data_byte;
         slot_ff[wr_ptr_ff].frame_start <= req_bus.frame_start;
         slot_ff[wr_ptr_ff].frame_end   <= req_bus.frame_end;
      end
   end

endmodule

### hw/rtl/irpd_seq.sv
// Back end: steps through header and bit segments and drives the response register.
module irpd_seq #(
   parameter int BITS_PER_BYTE = irpd_pkg::BITS_PER_BYTE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  irpd_pkg::cfg_type       cfg,
   input  irpd_pkg::queue_out_type q_out,
   output logic                    q_pop,
   irpd_rsp_if.source              rsp_bus
);

   localparam int CNT_W = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_BYTE - 1);

   irpd_pkg::phase_type             phase_ff, phase_in;
   logic                            active_ff, active_in;
   logic [CNT_W-1:0]                bit_cnt_ff, bit_cnt_in;
   logic [irpd_pkg::DATA_W-1:0]     data_ff, data_in;
   logic                            end_ff, end_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            carrier_ff;
   logic [irpd_pkg::DUR_W-1:0]      dur_ff;
   logic                            last_ff;
   logic                            done_ff;

   logic                            slot_free;
   logic                            fire;
   logic                            last_seg;
   logic                            load;
   logic                            seg_mark;
   logic [irpd_pkg::DUR_W-1:0]      seg_raw;
   logic [irpd_pkg::DUR_W-1:0]      seg_dur;

   // Output register frees up when empty or being taken
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign fire      = active_ff && slot_free;
   assign last_seg  = (phase_ff == irpd_pkg::PH_BIT_SPACE) && (bit_cnt_ff == LAST_BIT);
   assign load      = q_out.valid && (!active_ff || (fire && last_seg));
   assign q_pop     = load;

   // Select the segment of the current phase, clamp zero to the minimum
   always_comb begin
      case (phase_ff)
         irpd_pkg::PH_HDR_MARK: begin
            seg_mark = 1'b1;
            seg_raw  = cfg.header_mark_us;
         end
         irpd_pkg::PH_HDR_SPACE: begin
            seg_mark = 1'b0;
            seg_raw  = cfg.header_space_us;
         end
         irpd_pkg::PH_BIT_MARK: begin
            seg_mark = 1'b1;
            seg_raw  = cfg.bit_mark_us;
         end
         irpd_pkg::PH_BIT_SPACE: begin
            seg_mark = 1'b0;
            seg_raw  = data_ff[0] ? cfg.one_space_us : cfg.zero_space_us;
         end
         default: begin
            seg_mark = 1'b0;
            seg_raw  = irpd_pkg::MIN_DUR;
         end
      endcase
      seg_dur = (seg_raw == '0) ? irpd_pkg::MIN_DUR : seg_raw;
   end

   // Next phase, bit counter and byte shifter
   always_comb begin
      phase_in   = phase_ff;
      active_in  = active_ff;
      bit_cnt_in = bit_cnt_ff;
      data_in    = data_ff;
      end_in     = end_ff;
      if (load) begin
         active_in  = 1'b1;
         phase_in   = q_out.item.frame_start ? irpd_pkg::PH_HDR_MARK : irpd_pkg::PH_BIT_MARK;
         bit_cnt_in = '0;
         data_in    = q_out.item.data_byte;
         end_in     = q_out.item.frame_end;
      end else if (fire && last_seg) begin
         active_in = 1'b0;
      end else if (fire) begin
         case (phase_ff)
            irpd_pkg::PH_HDR_MARK:  phase_in = irpd_pkg::PH_HDR_SPACE;
            irpd_pkg::PH_HDR_SPACE: phase_in = irpd_pkg::PH_BIT_MARK;
            irpd_pkg::PH_BIT_MARK:  phase_in = irpd_pkg::PH_BIT_SPACE;
            irpd_pkg::PH_BIT_SPACE: begin
               phase_in   = irpd_pkg::PH_BIT_MARK;
               bit_cnt_in = bit_cnt_ff + 1'b1;
               data_in    = data_ff >> 1;
            end
            default: phase_in = irpd_pkg::PH_BIT_MARK;
         endcase
      end
   end

   // Hold the response until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= irpd_pkg::PH_BIT_MARK;
         active_ff    <= 1'b0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      end_ff  <= end_in;
      if (fire) begin
         carrier_ff <= seg_mark;
         dur_ff     <= seg_dur;
         last_ff    <= last_seg;
         done_ff    <= last_seg && end_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.carrier_on  = carrier_ff;
   assign rsp_bus.duration_us = dur_ff;
   assign rsp_bus.item_last   = last_ff;
   assign rsp_bus.frame_done  = done_ff;

   // Finishing a byte with nothing queued leaves the sequencer idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && last_seg && !q_out.valid) |=> !active_ff)
      else $error("sequencer still active after last segment");

   // A shown segment never has zero length
   a_dur_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dur_ff != '0))
      else $error("zero duration segment");

   // Frame end is flagged only on an item's last segment, which is a space
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (last_ff && !carrier_ff))
      else $error("frame end off the last segment");

   // Header phases only occur before the first bit
   a_hdr_first: assert property (@(posedge clock) disable iff (reset)
      (active_ff && (phase_ff == irpd_pkg::PH_HDR_MARK ||
                     phase_ff == irpd_pkg::PH_HDR_SPACE)) |-> (bit_cnt_ff == '0))
      else $error("header segment after bits started");

endmodule

### hw/rtl/ir_pulse_distance_encoder_core.sv
// IR pulse-distance encoder: request queue, segment sequencer and timing registers.
//
// Usage:
//   req_bus carries one byte per transfer with frame_start and frame_end flags.
//   rsp_bus returns one carrier segment per transfer: carrier_on, duration_us,
//   item_last on the final segment of a byte, frame_done on that segment when
//   the byte closed a frame. Bits go out least significant first, each as a
//   mark followed by a short (zero) or long (one) space; a header mark and
//   space come first when frame_start is set.
//   csr_bus writes the five timing registers by index; unknown indexes are
//   dropped. Write them only while no byte is in flight.
// Flow:
//   A byte sent into an idle block passes the queue and the sequencer state
//   before its first segment is registered. While rsp_bus.ready is high,
//   one segment goes out per cycle, set by the single response register, and
//   the next queued byte starts right after the last segment of the current one.
//   A byte is 2*BITS_PER_BYTE segments, plus 2 with a header (16 or 18 at 8 bits).
// Reset: queue empty, no response valid, timing registers at their defaults.
// Stall: a low rsp_bus.ready freezes the sequencer; the two-entry queue keeps
//   taking bytes until it fills, then req_bus.ready drops.
module ir_pulse_distance_encoder_core #(
   parameter int BITS_PER_BYTE = irpd_pkg::BITS_PER_BYTE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   irpd_req_if.sink   req_bus,
   irpd_rsp_if.source rsp_bus,
   irpd_csr_if.sink   csr_bus
);

   irpd_pkg::cfg_type       cfg;
   irpd_pkg::queue_out_type q_out;
   logic                    q_pop;

   // Timing registers
   irpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // Front end queue
   irpd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_out   (q_out),
      .q_pop   (q_pop)
   );

   // Back end sequencer
   irpd_seq #(
      .BITS_PER_BYTE (BITS_PER_BYTE)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_out   (q_out),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

### test/tb_ir_pulse_distance_encoder_core.sv
// Testbench for the IR pulse-distance encoder core: a directed table, then random framed traffic.
module tb_ir_pulse_distance_encoder_core;
   import irpd_pkg::*;

   localparam int NBITS       = BITS_PER_BYTE_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 4;
   localparam int PHASES      = 8;
   localparam int PHASE_BYTES = 50;
   localparam int MAX_WAIT    = 8;

   // Indexes past the last register; writes there must leave timing alone
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_MID = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic             carrier_on;
      logic [DUR_W-1:0] duration_us;
      logic             item_last;
      logic             frame_done;
   } segment_t;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_t;

   typedef struct {
      row_kind_t            kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [DUR_W-1:0]     value;
      logic [DATA_W-1:0]    data_byte;
      logic                 frame_start;
      logic                 frame_end;
      int                   want_count;   // 0: predictor only
      logic [DUR_W-1:0]     want_last;
   } stim_row_t;

   logic clock;
   logic reset;

   irpd_req_if req_bus ();
   irpd_rsp_if rsp_bus ();
   irpd_csr_if csr_bus ();

   ir_pulse_distance_encoder_core #(.BITS_PER_BYTE(NBITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cfg_type   timing;
   segment_t  pending_segments[$];
   stim_row_t plan[$];

   int errors        = 0;
   int bytes_sent    = 0;
   int frames_closed = 0;
   int segments_seen = 0;
   int reg_writes    = 0;
   int cycle_count   = 0;
   int req_max_gap   = MAX_WAIT;
   int rsp_max_stall = MAX_WAIT;
   int rsp_hold      = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d segments outstanding", $time, pending_segments.size());
         $display("** ir_pulse_distance_encoder_core: FAILED **");
         $finish;
      end
   end

   // Predictor: a zero register goes out as the shortest legal segment
   function automatic logic [DUR_W-1:0] floor_dur(input logic [DUR_W-1:0] d);
      return (d == '0) ? MIN_DUR : d;
   endfunction

   // Expand one byte into its mark/space segments and queue them
   function automatic int encode_byte_segments(input logic [DATA_W-1:0] b, input logic s,
                                               input logic e);
      segment_t seg;
      logic     one;
      int       n;
      n = 0;
      if (s) begin
         pending_segments.push_back(segment_t'{1'b1, floor_dur(timing.header_mark_us),
                                               1'b0, 1'b0});
         pending_segments.push_back(segment_t'{1'b0, floor_dur(timing.header_space_us),
                                               1'b0, 1'b0});
         n += 2;
      end
      for (int i = 0; i < NBITS; i++) begin
         // bits above the byte go out as zeros
         one = (i < DATA_W) && b[i % DATA_W];
         pending_segments.push_back(segment_t'{1'b1, floor_dur(timing.bit_mark_us),
                                               1'b0, 1'b0});
         pending_segments.push_back(segment_t'{1'b0,
            floor_dur(one ? timing.one_space_us : timing.zero_space_us), 1'b0, 1'b0});
         n += 2;
      end
      // flag the closing segment of this byte
      seg = pending_segments.pop_back();
      seg.item_last  = 1'b1;
      seg.frame_done = e;
      pending_segments.push_back(seg);
      return n;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Check each segment transfer against the oldest expectation
   always @(posedge clock) begin : check_rsp
      segment_t got;
      segment_t want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = segment_t'{rsp_bus.carrier_on, rsp_bus.duration_us, rsp_bus.item_last,
                          rsp_bus.frame_done};
         segments_seen++;
         if (pending_segments.size() == 0) begin
            $display("%0t: unexpected segment: expected none, actual carrier_on=%0b %0d us %0b %0b",
                     $time, got.carrier_on, got.duration_us, got.item_last, got.frame_done);
            errors++;
         end else begin
            want = pending_segments.pop_front();
            compare_field("carrier_on", want.carrier_on, got.carrier_on);
            compare_field("duration_us", want.duration_us, got.duration_us);
            compare_field("item_last", want.item_last, got.item_last);
            compare_field("frame_done", want.frame_done, got.frame_done);
         end
         rsp_hold = $urandom_range(0, rsp_max_stall);
      end
   end

   // Drive result ready, holding it low for the drawn stall
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Transfer one byte after a random gap and queue its segments
   task automatic push_byte(input logic [DATA_W-1:0] b, input logic s, input logic e,
                            output int count);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.frame_start <= s;
      req_bus.frame_end   <= e;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      count = encode_byte_segments(b, s, e);
      bytes_sent++;
      if (e)
         frames_closed++;
   endtask

   // Drop valid and wait until every queued segment has come back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_segments.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write one timing register; the block must be idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         REG_HEADER_MARK:  timing.header_mark_us  = value;
         REG_HEADER_SPACE: timing.header_space_us = value;
         REG_BIT_MARK:     timing.bit_mark_us     = value;
         REG_ZERO_SPACE:   timing.zero_space_us   = value;
         REG_ONE_SPACE:    timing.one_space_us    = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [DUR_W-1:0] rand_duration();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         default: return DUR_W'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic stim_row_t byte_row(input logic [DATA_W-1:0] b, input logic s,
                                          input logic e, input int want_count = 0,
                                          input logic [DUR_W-1:0] want_last = '0);
      stim_row_t r;
      r = '{ROW_BYTE, '0, '0, b, s, e, want_count, want_last};
      return r;
   endfunction

   function automatic stim_row_t csr_row(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [DUR_W-1:0] value);
      stim_row_t r;
      r = '{ROW_CSR, idx, value, '0, 1'b0, 1'b0, 0, '0};
      return r;
   endfunction

   initial begin : stimulus
      int n;
      int len;
      int sent;

      // Known values on every input while reset is held
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.frame_start = 1'b0;
      req_bus.frame_end   = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
      timing = '{HEADER_MARK_RST, HEADER_SPACE_RST, BIT_MARK_RST, ZERO_SPACE_RST,
                 ONE_SPACE_RST};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: defaults, all-ones timing, all-zero timing, then a typical set
      plan.push_back(byte_row(8'h00, 1'b1, 1'b0, 18, 16'd560));
      plan.push_back(byte_row(8'hFF, 1'b0, 1'b1, 16, 16'd1690));
      plan.push_back(byte_row(8'hA5, 1'b1, 1'b1));
      plan.push_back(byte_row(8'h5A, 1'b0, 1'b0));
      plan.push_back(byte_row(8'h01, 1'b1, 1'b0));
      plan.push_back(byte_row(8'h80, 1'b0, 1'b1));
      plan.push_back(csr_row(REG_HEADER_MARK, 16'hFFFF));
      plan.push_back(csr_row(REG_HEADER_SPACE, 16'hFFFF));
      plan.push_back(csr_row(REG_BIT_MARK, 16'hFFFF));
      plan.push_back(csr_row(REG_ZERO_SPACE, 16'hFFFF));
      plan.push_back(csr_row(REG_ONE_SPACE, 16'hFFFF));
      plan.push_back(csr_row(REG_SPARE_LO, 16'h0000));
      plan.push_back(csr_row(REG_SPARE_HI, 16'h1234));
      plan.push_back(byte_row(8'hFF, 1'b1, 1'b1, 18, 16'hFFFF));
      plan.push_back(byte_row(8'h00, 1'b0, 1'b0, 16, 16'hFFFF));
      plan.push_back(csr_row(REG_HEADER_MARK, 16'h0000));
      plan.push_back(csr_row(REG_HEADER_SPACE, 16'h0000));
      plan.push_back(csr_row(REG_BIT_MARK, 16'h0000));
      plan.push_back(csr_row(REG_ZERO_SPACE, 16'h0000));
      plan.push_back(csr_row(REG_ONE_SPACE, 16'h0000));
      plan.push_back(byte_row(8'hFF, 1'b1, 1'b1, 18, 16'd1));
      plan.push_back(byte_row(8'h00, 1'b1, 1'b0, 18, 16'd1));
      plan.push_back(csr_row(REG_HEADER_MARK, 16'd9000));
      plan.push_back(csr_row(REG_HEADER_SPACE, 16'd4500));
      plan.push_back(csr_row(REG_BIT_MARK, 16'd560));
      plan.push_back(csr_row(REG_ZERO_SPACE, 16'd565));
      plan.push_back(csr_row(REG_ONE_SPACE, 16'd1690));
      plan.push_back(csr_row(REG_SPARE_MID, 16'hFFFF));
      plan.push_back(byte_row(8'h3C, 1'b1, 1'b0));
      plan.push_back(byte_row(8'hC3, 1'b0, 1'b0));
      plan.push_back(byte_row(8'h55, 1'b0, 1'b1));
      plan.push_back(byte_row(8'hAA, 1'b1, 1'b1));

      // Walk the table; register writes wait for the block to drain
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_drained();
            write_reg(plan[i].idx, plan[i].value);
         end else begin
            push_byte(plan[i].data_byte, plan[i].frame_start, plan[i].frame_end, n);
            if (plan[i].want_count != 0) begin
               if (n != plan[i].want_count) begin
                  $display("%0t: row %0d segment count: expected %0d, actual %0d",
                           $time, i, plan[i].want_count, n);
                  errors++;
               end
               if (pending_segments[$].duration_us != plan[i].want_last) begin
                  $display("%0t: row %0d closing space: expected %0d, actual %0d",
                           $time, i, plan[i].want_last, pending_segments[$].duration_us);
                  errors++;
               end
            end
         end
      end

      // Random phases: new timing each phase, mostly well-formed frames
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         write_reg(REG_HEADER_MARK, rand_duration());
         write_reg(REG_HEADER_SPACE, rand_duration());
         write_reg(REG_BIT_MARK, rand_duration());
         write_reg(REG_ZERO_SPACE, rand_duration());
         write_reg(REG_ONE_SPACE, rand_duration());
         write_reg(CSR_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                   DUR_W'($urandom_range(0, 65535)));
         req_max_gap   = (phase % 2 == 0) ? 0 : MAX_WAIT;
         rsp_max_stall = (phase % 4 < 2) ? 0 : MAX_WAIT;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            if ($urandom_range(0, 4) != 0) begin
               len = $urandom_range(1, 6);
               for (int k = 0; k < len; k++)
                  push_byte(DATA_W'($urandom_range(0, 255)), k == 0, k == len - 1, n);
               sent += len;
            end else begin
               // stray byte with arbitrary flags
               push_byte(DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), n);
               sent++;
            end
            if ($urandom_range(0, 29) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("Covered %0d bytes (%0d closing a frame), %0d segments checked,", bytes_sent,
               frames_closed, segments_seen);
      $display("%0d register writes over %0d timing settings, idle and stalled handshakes.",
               reg_writes, PHASES + 4);
      if (errors == 0 && pending_segments.size() == 0) begin
         $display("** ir_pulse_distance_encoder_core: PASSED **");
      end else begin
         $display("** ir_pulse_distance_encoder_core: FAILED **");
      end
      $finish;
   end

endmodule
